### hw/rtl/cpc_pkg.sv
// Shared types and constants for the cursor pixel compositor.
`default_nettype none
package cpc_pkg;

    localparam int PIX_W   = 32;
    localparam int CHAN_W  = 8;
    localparam int PROD_W  = 2 * CHAN_W;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW  = 8;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [PIX_W-1:0]  t_pix;

    localparam logic KIND_PAL_WRITE = 1'b0;
    localparam logic KIND_COMPOSITE = 1'b1;

    localparam logic [PAL_AW-1:0] IDX_TRANSPARENT = 8'h00;
    localparam logic [PAL_AW-1:0] IDX_INVERT      = 8'hFF;

    localparam t_pix  INVERT_MASK = 32'h00FF_FFFF;
    localparam t_chan CHAN_MAX    = 8'hFF;
    localparam t_prod ROUND_BIAS  = 16'h0080;

endpackage
`default_nettype wire

### hw/rtl/cpc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cpc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hw/rtl/cpc_blend_lane.sv
// One color channel of the alpha blend: multiply stage, sum stage, rounding divide by 255.
`default_nettype none
module cpc_blend_lane
    import cpc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_chan i_dst,
    input  wire t_chan i_src,
    input  wire t_chan i_alpha,
    output t_chan      o_chan
);

    t_prod r_pd;
    t_prod r_ps;
    t_prod r_t;
    t_prod n_t;
    t_prod w_round;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pd <= i_dst * (CHAN_MAX - i_alpha);
            r_ps <= i_src * i_alpha;
            r_t  <= n_t;
        end
    end

    // sum stays below 2^16: 255*255 + 0x80
    assign n_t     = r_pd + r_ps + ROUND_BIAS;
    assign w_round = r_t + {8'h00, r_t[PROD_W-1:CHAN_W]};
    assign o_chan  = w_round[PROD_W-1:CHAN_W];

endmodule
`default_nettype wire

### hw/rtl/cursor_pixel_compositor_top.sv
// Top level of the cursor pixel compositor: input stage, palette RAM, blend lanes, output register.
//
// One word is accepted per clock while o_stall is low; a composite word yields its pixel from the
// output register, a palette write yields nothing. The four register stages are input/palette
// read, channel multiply, channel sum, and rounding plus mode select into the output
// register. The whole pipeline holds while a finished pixel is stalled at the output.
// The 256x32 palette is a RAM written on acceptance of a palette word and read by the
// cursor index of each composite word; it has no reset and needs no clearing pass.
// o_cfg_ready is always high; write the mode only while the pipeline is empty.
`default_nettype none
module cursor_pixel_compositor_top
    import cpc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic              i_cfg_data,
    input  wire logic              i_valid,
    output logic                   o_stall,
    input  wire logic              i_kind,
    input  wire logic [PIX_W-1:0]  i_cursor_pixel,
    input  wire logic [PIX_W-1:0]  i_dest_pixel,
    input  wire logic [PAL_AW-1:0] i_palette_index,
    input  wire logic [PIX_W-1:0]  i_palette_value,
    output logic                   o_valid,
    input  wire logic              i_stall,
    output logic [PIX_W-1:0]       o_pixel_out
);

    logic r_alpha_mode;
    logic w_en;
    logic w_accept;

    logic r1_valid, r2_valid, r3_valid, r_out_valid;
    logic r1_alpha, r2_alpha, r3_alpha;
    t_pix r1_src, r1_dst;
    t_pix r2_idx_pix, r3_idx_pix, n2_idx_pix;
    t_pix r_pixel_out;
    t_pix w_pal_rdata;
    t_chan w_red, w_green, w_blue;

    assign w_en      = !(r_out_valid && i_stall);
    assign o_stall   = !w_en;
    assign w_accept  = i_valid && w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_alpha_mode <= i_cfg_data;
        end
    end

    cpc_ram #(
        .WIDTH (PIX_W),
        .DEPTH (PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (w_accept && (i_kind == KIND_PAL_WRITE)),
        .i_waddr (i_palette_index),
        .i_wdata (i_palette_value),
        .i_re    (w_en),
        .i_raddr (i_cursor_pixel[PAL_AW-1:0]),
        .o_rdata (w_pal_rdata)
    );

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r1_valid    <= w_accept && (i_kind == KIND_COMPOSITE);
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r_out_valid <= r3_valid;
        end
    end

    always_comb begin
        priority if (r1_src[PAL_AW-1:0] == IDX_TRANSPARENT) begin
            n2_idx_pix = r1_dst;
        end else if (r1_src[PAL_AW-1:0] == IDX_INVERT) begin
            n2_idx_pix = r1_dst ^ INVERT_MASK;
        end else begin
            n2_idx_pix = w_pal_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_src      <= i_cursor_pixel;
            r1_dst      <= i_dest_pixel;
            r1_alpha    <= r_alpha_mode;
            r2_alpha    <= r1_alpha;
            r2_idx_pix  <= n2_idx_pix;
            r3_alpha    <= r2_alpha;
            r3_idx_pix  <= r2_idx_pix;
            r_pixel_out <= r3_alpha ? {8'h00, w_red, w_green, w_blue} : r3_idx_pix;
        end
    end

    cpc_blend_lane u_red (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dst   (r1_dst[23:16]),
        .i_src   (r1_src[23:16]),
        .i_alpha (r1_src[31:24]),
        .o_chan  (w_red)
    );

    cpc_blend_lane u_green (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dst   (r1_dst[15:8]),
        .i_src   (r1_src[15:8]),
        .i_alpha (r1_src[31:24]),
        .o_chan  (w_green)
    );

    cpc_blend_lane u_blue (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_dst   (r1_dst[7:0]),
        .i_src   (r1_src[7:0]),
        .i_alpha (r1_src[31:24]),
        .o_chan  (w_blue)
    );

    assign o_valid     = r_out_valid;
    assign o_pixel_out = r_pixel_out;

endmodule
`default_nettype wire
